// ===== src/hpds_pkg.sv =====
// ----------------------------------------------------------------------------
// hpds_pkg
// Types and constants shared by the pump and drain sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hpds_pkg;

	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_W     = 8;
	localparam int unsigned PHASE_W   = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CIRCULATION_PERIOD = 4'd0,
		CFG_BURSTS_PER_DRAIN   = 4'd1,
		CFG_PUMP_TICKS         = 4'd2,
		CFG_DRAIN_TICKS        = 4'd3,
		CFG_ALARM_ON_TICKS     = 4'd4,
		CFG_ALARM_OFF_TICKS    = 4'd5,
		CFG_ALARM_BURSTS       = 4'd6,
		CFG_BUZZER_LEVEL       = 4'd7
	} cfg_idx_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_COUNT   = 3'd0,
		PH_CIRC    = 3'd1,
		PH_DRAIN   = 3'd2,
		PH_REFILL  = 3'd3,
		PH_AL_ON   = 3'd4,
		PH_AL_OFF  = 3'd5,
		PH_TOP     = 3'd6,
		PH_TOP_ALT = 3'd7
	} phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] circulation_period;
		logic [CFG_W-1:0] bursts_per_drain;
		logic [CFG_W-1:0] pump_ticks;
		logic [CFG_W-1:0] drain_ticks;
		logic [CFG_W-1:0] alarm_on_ticks;
		logic [CFG_W-1:0] alarm_off_ticks;
		logic [CFG_W-1:0] alarm_bursts;
		logic [CFG_W-1:0] buzzer_level;
	} cfg_t;

	typedef struct packed {
		logic             tank_ok;
		logic             channel1_ok;
		logic             channel2_ok;
		logic             channel3_ok;
		logic             channel4_ok;
	} levels_t;

	typedef struct packed {
		logic               pump_on;
		logic               drain_open;
		logic [CFG_W-1:0]   buzzer_duty;
		logic [PHASE_W-1:0] phase;
	} drive_t;

	// a duration of zero behaves as one tick
	function automatic logic [CFG_W-1:0] dur_to_timer(input logic [CFG_W-1:0] dur);
		dur_to_timer = (dur == '0) ? '0 : dur - 1'b1;
	endfunction

endpackage

`default_nettype wire

// ===== src/hpds_cfg.sv =====
// ----------------------------------------------------------------------------
// hpds_cfg
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module hpds_cfg
	import hpds_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.circulation_period <= 8'd10;
			cfg_q.bursts_per_drain   <= 8'd5;
			cfg_q.pump_ticks         <= 8'd5;
			cfg_q.drain_ticks        <= 8'd4;
			cfg_q.alarm_on_ticks     <= 8'd2;
			cfg_q.alarm_off_ticks    <= 8'd2;
			cfg_q.alarm_bursts       <= 8'd4;
			cfg_q.buzzer_level       <= 8'd254;
		end else if (wr_en) begin
			case (wr_index)
				CFG_CIRCULATION_PERIOD: cfg_q.circulation_period <= wr_data;
				CFG_BURSTS_PER_DRAIN:   cfg_q.bursts_per_drain   <= wr_data;
				CFG_PUMP_TICKS:         cfg_q.pump_ticks         <= wr_data;
				CFG_DRAIN_TICKS:        cfg_q.drain_ticks        <= wr_data;
				CFG_ALARM_ON_TICKS:     cfg_q.alarm_on_ticks     <= wr_data;
				CFG_ALARM_OFF_TICKS:    cfg_q.alarm_off_ticks    <= wr_data;
				CFG_ALARM_BURSTS:       cfg_q.alarm_bursts       <= wr_data;
				CFG_BUZZER_LEVEL:       cfg_q.buzzer_level       <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== src/hpds_seq.sv =====
// ----------------------------------------------------------------------------
// hpds_seq
// Sequencer state and the per-tick decision chain.
// ----------------------------------------------------------------------------
`default_nettype none

module hpds_seq
	import hpds_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    step,
	input  wire levels_t levels,
	input  wire cfg_t    cfg,
	output drive_t       drive
);

	phase_t           phase_q, phase_d;
	logic [CFG_W-1:0] timer_q, timer_d;
	logic [CFG_W-1:0] tick_q, tick_d;
	logic [CFG_W-1:0] burst_q, burst_d;
	logic [CFG_W-1:0] al_burst_q, al_burst_d;
	logic             latched_q, latched_d;

	logic             do_top;
	logic             do_check;
	logic             do_after;
	logic             do_alarm;
	logic             all_ok;
	logic [CFG_W-1:0] al_limit;
	logic [CFG_W-1:0] al_burst_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TOP;
			timer_q    <= '0;
			tick_q     <= '0;
			burst_q    <= '0;
			al_burst_q <= '0;
			latched_q  <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_d;
			timer_q    <= timer_d;
			tick_q     <= tick_d;
			burst_q    <= burst_d;
			al_burst_q <= al_burst_d;
			latched_q  <= latched_d;
		end
	end

	assign all_ok = levels.channel1_ok & levels.channel2_ok
	              & levels.channel3_ok & levels.channel4_ok;
	assign al_limit     = (cfg.alarm_bursts == '0) ? 8'd1 : cfg.alarm_bursts;
	assign al_burst_inc = al_burst_q + 1'b1;

	always_comb begin
		phase_d    = phase_q;
		timer_d    = timer_q;
		tick_d     = tick_q;
		burst_d    = burst_q;
		al_burst_d = al_burst_q;
		latched_d  = latched_q;
		do_top     = 1'b0;
		do_check   = 1'b0;
		do_after   = 1'b0;
		do_alarm   = 1'b0;

		if (timer_q != '0) begin
			timer_d = timer_q - 1'b1;
		end else begin
			case (phase_q)
				PH_COUNT: begin
					if (tick_q >= cfg.circulation_period) begin
						tick_d  = '0;
						burst_d = burst_q + 1'b1;
						phase_d = PH_CIRC;
						timer_d = dur_to_timer(cfg.pump_ticks);
					end else begin
						do_after = 1'b1;
					end
				end
				PH_CIRC: begin
					if (burst_q >= cfg.bursts_per_drain) begin
						burst_d = '0;
						phase_d = PH_DRAIN;
						timer_d = dur_to_timer(cfg.drain_ticks);
					end else begin
						do_after = 1'b1;
					end
				end
				PH_DRAIN: begin
					do_check = latched_q;
					do_alarm = !latched_q;
				end
				PH_REFILL: begin
					do_check = 1'b1;
				end
				PH_AL_ON: begin
					phase_d = PH_AL_OFF;
					timer_d = dur_to_timer(cfg.alarm_off_ticks);
				end
				PH_AL_OFF: begin
					al_burst_d = al_burst_inc;
					if (al_burst_inc >= al_limit) begin
						do_top = 1'b1;
					end else begin
						phase_d = PH_AL_ON;
						timer_d = dur_to_timer(cfg.alarm_on_ticks);
					end
				end
				default: begin
					do_top = 1'b1;
				end
			endcase
		end

		// resolve the zero-time decision chain
		if (do_top) begin
			do_check = levels.tank_ok;
			do_alarm = !levels.tank_ok;
		end
		if (do_after) begin
			do_alarm = !latched_q;
		end
		if (do_check && !all_ok) begin
			phase_d = PH_REFILL;
			timer_d = dur_to_timer(cfg.pump_ticks);
		end
		if ((do_check && all_ok) || (do_after && latched_q)) begin
			latched_d = levels.tank_ok;
			tick_d    = tick_q + 1'b1;
			phase_d   = PH_COUNT;
			timer_d   = '0;
		end
		if (do_alarm) begin
			al_burst_d = '0;
			phase_d    = PH_AL_ON;
			timer_d    = dur_to_timer(cfg.alarm_on_ticks);
		end
	end

	always_comb begin
		drive.pump_on     = (phase_d == PH_CIRC) || (phase_d == PH_REFILL);
		drive.drain_open  = (phase_d == PH_DRAIN);
		drive.buzzer_duty = (phase_d == PH_AL_ON) ? cfg.buzzer_level : '0;
		drive.phase       = phase_d;
	end

endmodule

`default_nettype wire

// ===== src/hydroponic_pump_drain_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// hydroponic_pump_drain_sequencer_core
// Pump, drain and buzzer sequencer for a hydroponic rig, one tick per item.
// ----------------------------------------------------------------------------
// Each input transfer is one timebase tick carrying the tank and four channel
// level flags; each output transfer is the pump, drain, buzzer and phase
// drive for that tick, one result per item, in order.
// Channels use valid/stall: a transfer happens when valid is high and stall
// is low. An input transfer lands in an input register; when it advances, the
// decision logic updates the sequencer state and loads the result register.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// keeps one more item; in_stall rises only once both are full.
// The configuration port (cfg_valid/cfg_ready, always ready) writes one
// register per transfer; writes to unused indexes are dropped.
// Reset loads the default configuration, clears all counters and leaves the
// sequencer waiting to take its first decision from the top.
// ----------------------------------------------------------------------------
`default_nettype none

module hydroponic_pump_drain_sequencer_core
	import hpds_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 tank_ok,
	input  wire logic                 channel1_ok,
	input  wire logic                 channel2_ok,
	input  wire logic                 channel3_ok,
	input  wire logic                 channel4_ok,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      pump_on,
	output logic                      drain_open,
	output logic [CFG_W-1:0]          buzzer_duty,
	output logic [PHASE_W-1:0]        phase
);

	cfg_t    cfg;
	levels_t levels_s1;
	logic    valid_s1;
	logic    advance;
	logic    in_accept;
	drive_t  drive;
	drive_t  drive_q;
	logic    out_valid_q;

	assign cfg_ready = 1'b1;

	hpds_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			levels_s1.tank_ok     <= tank_ok;
			levels_s1.channel1_ok <= channel1_ok;
			levels_s1.channel2_ok <= channel2_ok;
			levels_s1.channel3_ok <= channel3_ok;
			levels_s1.channel4_ok <= channel4_ok;
		end
	end

	hpds_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.levels (levels_s1),
		.cfg    (cfg),
		.drive  (drive)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= drive;
		end
	end

	assign out_valid   = out_valid_q;
	assign pump_on     = drive_q.pump_on;
	assign drain_open  = drive_q.drain_open;
	assign buzzer_duty = drive_q.buzzer_duty;
	assign phase       = drive_q.phase;

endmodule

`default_nettype wire

// ===== verif/hpds_drive_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hpds_drive_checker
// Watches the register writes, the level transfers and the drive transfers of
// the pump and drain sequencer. Each level transfer steps a private copy of
// the sequencer and queues the drive it should produce. Each drive transfer is
// checked field by field against the oldest queued drive.
// ----------------------------------------------------------------------------
module hpds_drive_checker
	import hpds_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 tank_ok,
	input  logic                 channel1_ok,
	input  logic                 channel2_ok,
	input  logic                 channel3_ok,
	input  logic                 channel4_ok,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 pump_on,
	input  logic                 drain_open,
	input  logic [CFG_W-1:0]     buzzer_duty,
	input  logic [PHASE_W-1:0]   phase,
	output int unsigned          mismatches,
	output int unsigned          outstanding
);

	cfg_t             regs_model;
	phase_t           seq_phase;
	logic [CFG_W-1:0] seq_timer;
	logic [CFG_W-1:0] seq_ticks;
	logic [CFG_W-1:0] seq_bursts;
	logic [CFG_W-1:0] seq_alarm_bursts;
	logic             seq_tank_latched;

	drive_t  expected_drives[$];
	levels_t seen_levels;
	drive_t  seen_drive;
	drive_t  want_drive;

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void enter_phase(input phase_t ph, input logic [CFG_W-1:0] dur);
		seq_phase = ph;
		seq_timer = (dur == '0) ? '0 : dur - 8'd1;
	endfunction

	function automatic void sound_alarm();
		seq_alarm_bursts = '0;
		enter_phase(PH_AL_ON, regs_model.alarm_on_ticks);
	endfunction

	function automatic void count_tick(input logic tank);
		seq_tank_latched = tank;
		seq_ticks        = seq_ticks + 8'd1;
		seq_phase        = PH_COUNT;
		seq_timer        = '0;
	endfunction

	function automatic void check_channels(input levels_t lv);
		if (lv.channel1_ok && lv.channel2_ok && lv.channel3_ok && lv.channel4_ok)
			count_tick(lv.tank_ok);
		else
			enter_phase(PH_REFILL, regs_model.pump_ticks);
	endfunction

	function automatic void start_at_top(input levels_t lv);
		if (lv.tank_ok)
			check_channels(lv);
		else
			sound_alarm();
	endfunction

	function automatic void resume_counting(input levels_t lv);
		if (!seq_tank_latched)
			sound_alarm();
		else
			count_tick(lv.tank_ok);
	endfunction

	function automatic drive_t predict_drive(input levels_t lv);
		drive_t           d;
		logic [CFG_W-1:0] alarm_limit;
		if (seq_timer != '0) begin
			seq_timer = seq_timer - 8'd1;
		end else begin
			case (seq_phase)
				PH_COUNT: begin
					if (seq_ticks >= regs_model.circulation_period) begin
						seq_ticks  = '0;
						seq_bursts = seq_bursts + 8'd1;
						enter_phase(PH_CIRC, regs_model.pump_ticks);
					end else begin
						resume_counting(lv);
					end
				end
				PH_CIRC: begin
					if (seq_bursts >= regs_model.bursts_per_drain) begin
						seq_bursts = '0;
						enter_phase(PH_DRAIN, regs_model.drain_ticks);
					end else begin
						resume_counting(lv);
					end
				end
				PH_DRAIN: begin
					if (seq_tank_latched)
						check_channels(lv);
					else
						sound_alarm();
				end
				PH_REFILL: check_channels(lv);
				PH_AL_ON: enter_phase(PH_AL_OFF, regs_model.alarm_off_ticks);
				PH_AL_OFF: begin
					alarm_limit = (regs_model.alarm_bursts == '0) ? 8'd1 : regs_model.alarm_bursts;
					seq_alarm_bursts = seq_alarm_bursts + 8'd1;
					if (seq_alarm_bursts >= alarm_limit)
						start_at_top(lv);
					else
						enter_phase(PH_AL_ON, regs_model.alarm_on_ticks);
				end
				default: start_at_top(lv);
			endcase
		end
		d.pump_on     = (seq_phase == PH_CIRC) || (seq_phase == PH_REFILL);
		d.drain_open  = (seq_phase == PH_DRAIN);
		d.buzzer_duty = (seq_phase == PH_AL_ON) ? regs_model.buzzer_level : '0;
		d.phase       = seq_phase;
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_model.circulation_period = 8'd10;
			regs_model.bursts_per_drain   = 8'd5;
			regs_model.pump_ticks         = 8'd5;
			regs_model.drain_ticks        = 8'd4;
			regs_model.alarm_on_ticks     = 8'd2;
			regs_model.alarm_off_ticks    = 8'd2;
			regs_model.alarm_bursts       = 8'd4;
			regs_model.buzzer_level       = 8'd254;
			seq_phase        = PH_TOP;
			seq_timer        = '0;
			seq_ticks        = '0;
			seq_bursts       = '0;
			seq_alarm_bursts = '0;
			seq_tank_latched = 1'b0;
			expected_drives.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CIRCULATION_PERIOD: regs_model.circulation_period = cfg_data;
					CFG_BURSTS_PER_DRAIN:   regs_model.bursts_per_drain   = cfg_data;
					CFG_PUMP_TICKS:         regs_model.pump_ticks         = cfg_data;
					CFG_DRAIN_TICKS:        regs_model.drain_ticks        = cfg_data;
					CFG_ALARM_ON_TICKS:     regs_model.alarm_on_ticks     = cfg_data;
					CFG_ALARM_OFF_TICKS:    regs_model.alarm_off_ticks    = cfg_data;
					CFG_ALARM_BURSTS:       regs_model.alarm_bursts       = cfg_data;
					CFG_BUZZER_LEVEL:       regs_model.buzzer_level       = cfg_data;
					default: ;
				endcase
			end
			// drive transfer first: it can never belong to a level transfer of this edge
			if (out_valid && !out_stall) begin
				seen_drive = {pump_on, drain_open, buzzer_duty, phase};
				if (expected_drives.size() == 0) begin
					report_mismatch($sformatf("drive transfer with none expected, phase %0d",
						seen_drive.phase));
				end else begin
					want_drive = expected_drives.pop_front();
					if (seen_drive.pump_on != want_drive.pump_on)
						report_mismatch($sformatf("pump_on got %0d expected %0d",
							seen_drive.pump_on, want_drive.pump_on));
					if (seen_drive.drain_open != want_drive.drain_open)
						report_mismatch($sformatf("drain_open got %0d expected %0d",
							seen_drive.drain_open, want_drive.drain_open));
					if (seen_drive.buzzer_duty != want_drive.buzzer_duty)
						report_mismatch($sformatf("buzzer_duty got %0d expected %0d",
							seen_drive.buzzer_duty, want_drive.buzzer_duty));
					if (seen_drive.phase != want_drive.phase)
						report_mismatch($sformatf("phase got %0d expected %0d",
							seen_drive.phase, want_drive.phase));
				end
			end
			if (in_valid && !in_stall) begin
				seen_levels = {tank_ok, channel1_ok, channel2_ok, channel3_ok, channel4_ok};
				expected_drives.push_back(predict_drive(seen_levels));
			end
			outstanding = expected_drives.size();
		end
	end

endmodule

// ===== verif/tb_hydroponic_pump_drain_sequencer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hydroponic_pump_drain_sequencer_core
// Drives level ticks into the pump and drain sequencer in random bursts while
// the drive side stalls in changing patterns. A short directed run under the
// reset registers is followed by random runs under several register settings
// (all zero, all ones, all 255, small and random values), with an unused
// register index written now and then. The checker beside the block predicts
// and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_hydroponic_pump_drain_sequencer_core;
	import hpds_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES  = 4;

	typedef enum int unsigned {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_e;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [CFG_W-1:0]     cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic                 tank_ok     = 1'b0;
	logic                 channel1_ok = 1'b0;
	logic                 channel2_ok = 1'b0;
	logic                 channel3_ok = 1'b0;
	logic                 channel4_ok = 1'b0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic                 pump_on;
	logic                 drain_open;
	logic [CFG_W-1:0]     buzzer_duty;
	logic [PHASE_W-1:0]   phase;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned burst_left  = 1;
	int unsigned idle_cycles = 0;
	int unsigned stall_span  = 0;
	stall_mode_e stall_mode  = STALL_NONE;

	hydroponic_pump_drain_sequencer_core uut (.*);

	hpds_drive_checker checker_i (.*);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= stall_mode_e'($urandom_range(0, 3));
			stall_span <= $urandom_range(8, 80);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
			default:     out_stall <= (stall_span % 3 != 0);
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_levels(input levels_t lv);
		in_valid <= 1'b1;
		{tank_ok, channel1_ok, channel2_ok, channel3_ok, channel4_ok} <= lv;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (burst_left > 1) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
			                                         : $urandom_range(1, 12);
		end
	endtask

	task automatic drain_pending();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic write_config(input cfg_t c, input bit stray);
		drain_pending();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (stray)
			write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_BUZZER_LEVEL + 1)),
				CFG_W'($urandom_range(0, 255)));
		write_reg(CFG_CIRCULATION_PERIOD, c.circulation_period);
		write_reg(CFG_BURSTS_PER_DRAIN, c.bursts_per_drain);
		write_reg(CFG_PUMP_TICKS, c.pump_ticks);
		write_reg(CFG_DRAIN_TICKS, c.drain_ticks);
		write_reg(CFG_ALARM_ON_TICKS, c.alarm_on_ticks);
		write_reg(CFG_ALARM_OFF_TICKS, c.alarm_off_ticks);
		write_reg(CFG_ALARM_BURSTS, c.alarm_bursts);
		write_reg(CFG_BUZZER_LEVEL, c.buzzer_level);
		cfg_valid <= 1'b0;
	endtask

	// mostly all levels good so counting reaches circulation and drain
	function automatic levels_t random_levels();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			random_levels = '1;
		else if (pick < 88)
			random_levels = {1'b0, 4'($urandom)};
		else
			random_levels = 5'($urandom);
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.circulation_period = CFG_W'($urandom_range(0, 8));
		c.bursts_per_drain   = CFG_W'($urandom_range(0, 8));
		c.pump_ticks         = CFG_W'($urandom_range(0, 8));
		c.drain_ticks        = CFG_W'($urandom_range(0, 8));
		c.alarm_on_ticks     = CFG_W'($urandom_range(0, 8));
		c.alarm_off_ticks    = CFG_W'($urandom_range(0, 8));
		c.alarm_bursts       = CFG_W'($urandom_range(0, 8));
		c.buzzer_level       = CFG_W'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic run_random(input int unsigned count);
		repeat (count) send_levels(random_levels());
	endtask

	initial begin
		levels_t directed [24];
		cfg_t    setting;
		directed = '{5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111,
		             5'b11111, 5'b11111, 5'b11111, 5'b11111, 5'b11111,
		             5'b10111, 5'b11011, 5'b11101, 5'b11110, 5'b00000, 5'b01111,
		             5'b11111, 5'b10000, 5'b11111, 5'b01111, 5'b11111, 5'b11111,
		             5'b00111};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_levels(directed[i]);

		setting = '{8'd3, 8'd2, 8'd2, 8'd2, 8'd1, 8'd1, 8'd2, 8'($urandom)};
		write_config(setting, 1'b0);
		run_random(75);
		// hold off until every drive has come back
		drain_pending();
		run_random(75);

		write_config('0, 1'b1);
		run_random(100);

		write_config('1, 1'b0);
		run_random(60);

		// period drops from 255 to 1 with ticks already counted
		setting = {8{8'd1}};
		setting.buzzer_level = CFG_W'($urandom_range(0, 255));
		write_config(setting, 1'b0);
		run_random(100);

		repeat (3) begin
			write_config(random_cfg(), 1'b1);
			run_random(80);
		end

		drain_pending();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
